// ===== src/wnov_pkg.sv =====
// Shared types and constants of the windowed nearest-object vote block.
package wnov_pkg;

  // Fixed field widths.
  localparam int SLOT_W  = 4;
  localparam int PID_W   = 25;
  localparam int TID_W   = 32;
  localparam int CNT_W   = 16;
  localparam int TICK_W  = 32;
  localparam int WSLOT_W = 5;
  localparam int REACH_W = 16;
  localparam int LIMSQ_W = 32;
  localparam int BEST_W  = 35;

  // Squared distance that stands for "no player seen yet this tick".
  localparam logic [BEST_W-1:0] BEST_INIT = '1;

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int REG_IW = 2;
  localparam logic [REG_IW-1:0] REG_WINDOW = 2'd0;
  localparam logic [REG_IW-1:0] REG_REACH  = 2'd1;
  localparam logic [REG_IW-1:0] REG_LIMIT  = 2'd2;

  localparam logic [CNT_W-1:0]   WINDOW_RESET = 16'd25;
  localparam logic [REACH_W-1:0] REACH_RESET  = 16'd512;
  localparam logic [15:0]        LIMIT_RESET  = 16'd256;
  localparam logic [LIMSQ_W-1:0] LIMSQ_RESET  = 32'd65536;

  // Operand select of the shared squaring multiplier.
  localparam int MSEL_W = 2;
  localparam logic [MSEL_W-1:0] MUL_LIFT = 2'd0;
  localparam logic [MSEL_W-1:0] MUL_X    = 2'd1;
  localparam logic [MSEL_W-1:0] MUL_Y    = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]          window_ticks;
    logic signed [REACH_W-1:0] reach_height;
    logic [LIMSQ_W-1:0]        near_limit_sq;
  } cfg_t;

  typedef struct packed {
    logic              take;
    logic              mul_en;
    logic [MSEL_W-1:0] mul_sel;
    logic              sum;
    logic              vote;
    logic              scan;
    logic              emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic in_ball;
    logic cur_last;
    logic window_done;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/wnov_in_if.sv =====
// Sample request channel of the windowed nearest-object vote block.
interface wnov_in_if #(
  parameter int COORD_WIDTH = 16
);
  import wnov_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [SLOT_W-1:0]         slot;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;
  logic signed [COORD_WIDTH-1:0] height;
  logic signed [PID_W-1:0]   player_ident;
  logic signed [TID_W-1:0]   team_ident;

  modport source (output valid, slot, x_pos, y_pos, height, player_ident, team_ident,
                  input ready);
  modport sink (input valid, slot, x_pos, y_pos, height, player_ident, team_ident,
                output ready);
endinterface

// ===== src/wnov_out_if.sv =====
// Result request channel of the windowed nearest-object vote block.
interface wnov_out_if;
  import wnov_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [TICK_W-1:0]         window_start;
  logic signed [WSLOT_W-1:0] winner_slot;
  logic signed [PID_W-1:0]   winner_player;
  logic signed [TID_W-1:0]   winner_team;

  modport source (output valid, window_start, winner_slot, winner_player, winner_team,
                  input ready);
  modport sink (input valid, window_start, winner_slot, winner_player, winner_team,
                output ready);
endinterface

// ===== src/wnov_cfg.sv =====
// Configuration register file with its APB-style write and read port.
module wnov_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wnov_pkg::APB_AW-1:0]  paddr,
  input  logic [wnov_pkg::APB_DW-1:0]  pwdata,
  output logic [wnov_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output wnov_pkg::cfg_t               cfg
);
  import wnov_pkg::*;

  logic [CNT_W-1:0]          window_ticks_r;
  logic signed [REACH_W-1:0] reach_height_r;
  logic [15:0]               near_limit_r;
  logic [LIMSQ_W-1:0]        near_limit_sq_r;
  logic [LIMSQ_W-1:0]        near_limit_sq_nxt;
  logic [REG_IW-1:0]         reg_idx;
  logic [15:0]               wdata16;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wdata16 = pwdata[15:0];

  // The limit is kept squared so the per-tick check is a plain compare.
  assign near_limit_sq_nxt = LIMSQ_W'(wdata16) * LIMSQ_W'(wdata16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r  <= WINDOW_RESET;
      reach_height_r  <= REACH_RESET;
      near_limit_r    <= LIMIT_RESET;
      near_limit_sq_r <= LIMSQ_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW: window_ticks_r <= wdata16;
        REG_REACH:  reach_height_r <= wdata16;
        REG_LIMIT: begin
          near_limit_r    <= wdata16;
          near_limit_sq_r <= near_limit_sq_nxt;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = APB_DW'(window_ticks_r);
      REG_REACH:  prdata = APB_DW'(unsigned'(reach_height_r));
      REG_LIMIT:  prdata = APB_DW'(near_limit_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.window_ticks  = window_ticks_r;
  assign cfg.reach_height  = reach_height_r;
  assign cfg.near_limit_sq = near_limit_sq_r;

endmodule

// ===== src/wnov_ctrl.sv =====
// Sequencing state machine of the windowed nearest-object vote block.
module wnov_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wnov_pkg::dp_status_t st,
  output wnov_pkg::dp_cmd_t    cmd
);
  import wnov_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LSQ  = 3'd1;
  localparam logic [2:0] ST_SQX  = 3'd2;
  localparam logic [2:0] ST_SQY  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_VOTE = 3'd5;
  localparam logic [2:0] ST_SCAN = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && st.in_range) begin
          state_nxt = st.in_ball ? ST_LSQ : ST_SQX;
        end
      end
      ST_LSQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LIFT;
        state_nxt   = ST_IDLE;
      end
      ST_SQX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = st.cur_last ? ST_VOTE : ST_IDLE;
      end
      ST_VOTE: begin
        cmd.vote  = 1'b1;
        state_nxt = st.window_done ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/wnov_dp.sv =====
// Datapath: ball state, shared squaring multiplier, nearest search, votes and result.
module wnov_dp #(
  parameter int NUM_OBJECTS = 11,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wnov_pkg::cfg_t                      cfg,
  input  wnov_pkg::dp_cmd_t                   cmd,
  output wnov_pkg::dp_status_t                st,
  input  logic [wnov_pkg::SLOT_W-1:0]         slot,
  input  logic signed [COORD_WIDTH-1:0]       x_pos,
  input  logic signed [COORD_WIDTH-1:0]       y_pos,
  input  logic signed [COORD_WIDTH-1:0]       height,
  input  logic signed [wnov_pkg::PID_W-1:0]   player_ident,
  input  logic signed [wnov_pkg::TID_W-1:0]   team_ident,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wnov_pkg::TICK_W-1:0]         window_start,
  output logic signed [wnov_pkg::WSLOT_W-1:0] winner_slot,
  output logic signed [wnov_pkg::PID_W-1:0]   winner_player,
  output logic signed [wnov_pkg::TID_W-1:0]   winner_team
);
  import wnov_pkg::*;

  localparam int IDXW = $clog2(NUM_OBJECTS);
  localparam int SLW  = ((IDXW > SLOT_W) ? IDXW : SLOT_W) + 1;
  localparam int DFW  = COORD_WIDTH + 1;
  localparam int LW   = (COORD_WIDTH > REACH_W) ? COORD_WIDTH : REACH_W;
  localparam int EW   = LW + 1;
  localparam int MW   = (DFW > LW + 1) ? DFW : LW + 1;
  localparam int SQW  = 2 * LW;
  localparam int DW   = (SQW + 2 > BEST_W) ? SQW + 2 : BEST_W;

  // Incoming sample decode.
  logic [SLW-1:0]  slot_ext;
  logic [IDXW-1:0] slot_idx;
  logic            in_range;
  logic            in_last;
  logic            take_ok;

  assign slot_ext = SLW'(slot);
  assign slot_idx = IDXW'(slot_ext);
  assign in_range = slot_ext < SLW'(NUM_OBJECTS);
  assign in_last  = slot_ext == SLW'(NUM_OBJECTS - 1);
  assign take_ok  = cmd.take & in_range;

  // Ball state and per-item working registers.
  logic signed [COORD_WIDTH-1:0] ball_x_r;
  logic signed [COORD_WIDTH-1:0] ball_y_r;
  logic [LW-1:0]                 lift_r;
  logic [SQW-1:0]                lift_sq_r;
  logic signed [DFW-1:0]         dx_r;
  logic signed [DFW-1:0]         dy_r;
  logic [SQW-1:0]                prod_r;
  logic [SQW-1:0]                acc_r;
  logic [IDXW-1:0]               cur_slot_r;
  logic                          cur_last_r;

  // Tick and window state.
  logic [DW-1:0]     best_r;
  logic [IDXW-1:0]   best_slot_r;
  logic [CNT_W-1:0]  counts_r [NUM_OBJECTS];
  logic [PID_W-1:0]  pid_r [NUM_OBJECTS];
  logic [TID_W-1:0]  tid_r [NUM_OBJECTS];
  logic [CNT_W-1:0]  ticks_r;
  logic [TICK_W-1:0] tick_num_r;
  logic [TICK_W-1:0] wfirst_r;
  logic [IDXW-1:0]   scan_idx_r;
  logic [IDXW-1:0]   top_r;
  logic [CNT_W-1:0]  top_cnt_r;

  // Result register.
  logic                      out_valid_r;
  logic [TICK_W-1:0]         out_wstart_r;
  logic [WSLOT_W-1:0]        out_slot_r;
  logic [PID_W-1:0]          out_pid_r;
  logic [TID_W-1:0]          out_tid_r;

  // Ball height above the reach threshold.
  logic signed [EW-1:0] h_ext;
  logic signed [EW-1:0] reach_ext;
  logic signed [EW-1:0] lift_diff;
  logic [LW-1:0]        lift_val;

  assign h_ext     = EW'(height);
  assign reach_ext = EW'($signed(cfg.reach_height));
  assign lift_diff = h_ext - reach_ext;
  assign lift_val  = (h_ext > reach_ext) ? LW'(lift_diff) : '0;

  // Shared squaring multiplier.
  logic signed [MW-1:0]   mul_a;
  logic signed [2*MW-1:0] mul_p;
  logic [SQW-1:0]         mul_sq;

  always_comb begin
    case (cmd.mul_sel)
      MUL_LIFT: mul_a = MW'($signed({1'b0, lift_r}));
      MUL_X:    mul_a = MW'(dx_r);
      MUL_Y:    mul_a = MW'(dy_r);
      default:  mul_a = '0;
    endcase
  end

  assign mul_p  = mul_a * mul_a;
  assign mul_sq = SQW'(mul_p);

  // Distance of the current player and the tick's vote.
  logic [DW-1:0]     d2;
  logic [IDXW-1:0]   vote_idx;
  logic [IDXW-1:0]   cnt_addr;
  logic [CNT_W-1:0]  cnt_rd;
  logic [CNT_W-1:0]  ticks_nxt;
  logic [CNT_W-1:0]  goal;

  assign d2 = DW'(acc_r) + DW'(prod_r) + DW'(lift_sq_r);

  assign vote_idx = ((best_slot_r != '0) && (best_r <= DW'(cfg.near_limit_sq)))
                    ? best_slot_r : '0;
  assign cnt_addr = cmd.vote ? vote_idx : scan_idx_r;
  assign cnt_rd   = counts_r[cnt_addr];

  assign ticks_nxt = ticks_r + CNT_W'(1);
  assign goal      = (cfg.window_ticks == '0) ? CNT_W'(1) : cfg.window_ticks;

  assign st.in_range    = in_range;
  assign st.in_ball     = slot == '0;
  assign st.cur_last    = cur_last_r;
  assign st.window_done = ticks_nxt >= goal;
  assign st.scan_last   = scan_idx_r == IDXW'(NUM_OBJECTS - 1);
  assign st.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ball_x_r    <= '0;
      ball_y_r    <= '0;
      lift_r      <= '0;
      lift_sq_r   <= '0;
      best_r      <= DW'(BEST_INIT);
      best_slot_r <= '0;
      ticks_r     <= '0;
      tick_num_r  <= '0;
      wfirst_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_OBJECTS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (take_ok && slot == '0) begin
        ball_x_r <= x_pos;
        ball_y_r <= y_pos;
        lift_r   <= lift_val;
      end
      if (cmd.mul_en && cmd.mul_sel == MUL_LIFT) begin
        lift_sq_r <= mul_sq;
      end
      if (cmd.sum && d2 < best_r) begin
        best_r      <= d2;
        best_slot_r <= cur_slot_r;
      end
      if (cmd.vote) begin
        if (cnt_rd != '1) begin
          counts_r[vote_idx] <= cnt_rd + CNT_W'(1);
        end
        best_r      <= DW'(BEST_INIT);
        best_slot_r <= '0;
        ticks_r     <= ticks_nxt;
        tick_num_r  <= tick_num_r + TICK_W'(1);
      end
      if (cmd.emit) begin
        for (int i = 0; i < NUM_OBJECTS; i++) begin
          counts_r[i] <= '0;
        end
        ticks_r     <= '0;
        wfirst_r    <= tick_num_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and payload registers without reset.
  always_ff @(posedge clk) begin
    if (take_ok) begin
      dx_r       <= DFW'(ball_x_r) - DFW'(x_pos);
      dy_r       <= DFW'(ball_y_r) - DFW'(y_pos);
      cur_slot_r <= slot_idx;
      cur_last_r <= in_last;
      if (ticks_r == '0) begin
        pid_r[slot_idx] <= player_ident;
        tid_r[slot_idx] <= team_ident;
      end
    end
    if (cmd.mul_en) begin
      prod_r <= mul_sq;
      if (cmd.mul_sel == MUL_Y) begin
        acc_r <= prod_r;
      end
    end
    if (cmd.vote) begin
      scan_idx_r <= '0;
      top_r      <= '0;
      top_cnt_r  <= '0;
    end
    if (cmd.scan) begin
      if (cnt_rd > top_cnt_r) begin
        top_r     <= scan_idx_r;
        top_cnt_r <= cnt_rd;
      end
      scan_idx_r <= scan_idx_r + IDXW'(1);
    end
    if (cmd.emit) begin
      out_wstart_r <= wfirst_r;
      out_slot_r   <= WSLOT_W'(top_r) - WSLOT_W'(1);
      out_pid_r    <= pid_r[top_r];
      out_tid_r    <= tid_r[top_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign window_start  = out_wstart_r;
  assign winner_slot   = out_slot_r;
  assign winner_player = out_pid_r;
  assign winner_team   = out_tid_r;

endmodule

// ===== src/windowed_nearest_object_vote.sv =====
// Top level of the windowed nearest-object vote block.
//
// The block takes tracked object samples, NUM_OBJECTS per tick in slot order
// (slot 0 is the ball, the rest are players, the last slot closes the tick),
// and votes each tick for the player nearest the ball in squared distance,
// where ball height above reach_height counts as a third axis and the lower
// slot wins ties. A tick whose nearest player lies beyond near_limit, or that
// saw no player, votes for nobody. After window_ticks ticks one result request
// carries the window's first tick number, the winning slot minus one (-1 for
// nobody) and the ids captured at that slot during the window's first tick;
// the votes are then cleared. Samples with a slot at or beyond NUM_OBJECTS are
// taken and dropped. A ball sample goes on to square its lift above reach, and
// a player sample steps the one squaring multiplier through dx squared and dy
// squared in turn before the sum and compare. The tick's last sample then
// votes, and a window's last tick goes on to walk all NUM_OBJECTS vote counts
// and load the result register, a load that waits while that register still
// holds an earlier result nobody has taken. The result register lets the next
// samples be taken while a result waits. Configuration registers sit at byte
// addresses 0 (window_ticks), 4 (reach_height) and 8 (near_limit) and are
// to be written only while the block is idle.
module windowed_nearest_object_vote #(
  parameter int NUM_OBJECTS = 11,
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wnov_in_if.sink                     in_ch,
  wnov_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wnov_pkg::APB_AW-1:0] paddr,
  input  logic [wnov_pkg::APB_DW-1:0] pwdata,
  output logic [wnov_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import wnov_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;

  // Register file; the near limit is held squared for the per-tick compare.
  wnov_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Controller: accepts samples only when the datapath is free and steps the
  // shared multiplier, the vote update and the count walk.
  wnov_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: ball state, distances, nearest player, votes, ids and the
  // result register that drives the output channel.
  wnov_dp #(
    .NUM_OBJECTS (NUM_OBJECTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .st            (st),
    .slot          (in_ch.slot),
    .x_pos         (COORD_WIDTH'(in_ch.x_pos)),
    .y_pos         (COORD_WIDTH'(in_ch.y_pos)),
    .height        (COORD_WIDTH'(in_ch.height)),
    .player_ident  (in_ch.player_ident),
    .team_ident    (in_ch.team_ident),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .window_start  (out_ch.window_start),
    .winner_slot   (out_ch.winner_slot),
    .winner_player (out_ch.winner_player),
    .winner_team   (out_ch.winner_team)
  );

endmodule
